/* rtl/modular_exponentiation_macros.svh */
// Assertion macros shared by the modular exponentiation RTL.
// Included by the modules that check their own control logic.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MEXP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modexp check failed");

// Next-cycle implication, checked out of reset.
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modexp check failed");

`endif

/* rtl/mexp_pkg.sv */
// Shared types and constants for the modular exponentiation block.
// Depends on nothing; used by mexp_mulmod and modular_exponentiation.
package mexp_pkg;

    // Configuration register indexes.
    localparam logic REG_MODULUS  = 1'b0;
    localparam logic REG_EXPONENT = 1'b1;

    // Status of the modular multiplier as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } mexp_mul_status_t;

endpackage

/* rtl/mexp_cell.sv */
// One cell of the multiplier-bit chain: holds one bit and passes it on.
// Depends on nothing.
module mexp_cell
(
    input  logic clk,
    input  logic load,
    input  logic shift,
    input  logic load_bit,
    input  logic prev_bit,
    output logic q
);

    logic bit_reg;
    logic bit_next;

    always_comb
    begin
        bit_next = bit_reg;
        if (load)
        begin
            bit_next = load_bit;
        end
        else if (shift)
        begin
            bit_next = prev_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
    end

    assign q = bit_reg;

endmodule

/* rtl/mexp_mulmod.sv */
// Bit-serial modular multiplier: (a * b) mod n, one multiplier bit per cycle.
// Depends on mexp_pkg, mexp_cell and the shared assertion macros.
`include "modular_exponentiation_macros.svh"

module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    input  logic [WORD_BITS-1:0] n,
    output mexp_mul_status_t     status,
    output logic [WORD_BITS-1:0] product
);

    localparam int CNT_W = $clog2(WORD_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] n_reg, n_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;

    logic [WORD_BITS-1:0] chain;
    logic [WORD_BITS:0]   dbl;
    logic [WORD_BITS-1:0] dbl_red;
    logic [WORD_BITS-1:0] addend;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS-1:0] sum_red;

    // The multiplier is scanned from its top bit; the chain moves toward the top.
    for (genvar i = 0; i < WORD_BITS; i++)
    begin : g_cells
        mexp_cell u_cell
        (
            .clk      (clk),
            .load     (start),
            .shift    (busy_reg),
            .load_bit (b[i]),
            .prev_bit ((i == 0) ? 1'b0 : chain[(i == 0) ? 0 : i - 1]),
            .q        (chain[i])
        );
    end

    // acc = 2*acc + bit*a, both additions reduced below n.
    always_comb
    begin
        dbl     = {1'b0, acc_reg} + {1'b0, acc_reg};
        dbl_red = (dbl >= {1'b0, n_reg}) ? WORD_BITS'(dbl - {1'b0, n_reg})
                                         : dbl[WORD_BITS-1:0];
        addend  = chain[WORD_BITS-1] ? a_reg : '0;
        sum     = {1'b0, dbl_red} + {1'b0, addend};
        sum_red = (sum >= {1'b0, n_reg}) ? WORD_BITS'(sum - {1'b0, n_reg})
                                         : sum[WORD_BITS-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        n_next    = n_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WORD_BITS);
            a_next    = a;
            n_next    = n;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = sum_red;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        n_reg   <= n_next;
        acc_reg <= acc_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign product     = acc_reg;

    `MEXP_ASSERT_NOW(a_mul_start_idle, clk, rst_n, start, !busy_reg)
    `MEXP_ASSERT_NOW(a_mul_reduced, clk, rst_n, done_reg, acc_reg < n_reg)
    `MEXP_ASSERT_NEXT(a_mul_done_idle, clk, rst_n, done_reg, !busy_reg)

endmodule

/* rtl/modular_exponentiation.sv */
// Top level of the modular exponentiation block: registers and sequencer.
// Depends on mexp_pkg, mexp_mulmod (with its mexp_cell chain) and the macros.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------
//  input    | start & !busy          | base_value
//  result   | done (one-cycle pulse) | power_result
//  config   | wr_en                  | wr_index, wr_data
//
// Each modular product holds the one shared bit-serial multiplier; a decide state
// follows the base reduction and every squaring. An item costs one reduction of the
// base plus one product per set exponent bit and one squaring per exponent bit below
// the top set bit. A zero exponent gives a result of 1, with done in the cycle after
// the accept. One item is in work at a time; busy is high until done. Reset sets the
// modulus to 1 and the exponent to 0; the result has no stall.
`include "modular_exponentiation_macros.svh"

module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] base_value,
    output logic                 done,
    output logic [WORD_BITS-1:0] power_result,
    input  logic                 wr_en,
    input  logic                 wr_index,
    input  logic [WORD_BITS-1:0] wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_DECIDE,
        ST_MULT,
        ST_SQUARE
    } state_t;

    state_t               state_reg;
    logic [WORD_BITS-1:0] modulus_reg;
    logic [WORD_BITS-1:0] exponent_reg;
    logic [WORD_BITS-1:0] e_reg;
    logic [WORD_BITS-1:0] res_reg;
    logic [WORD_BITS-1:0] pow_reg;
    logic [WORD_BITS-1:0] out_reg;
    logic                 done_reg;
    logic                 mul_start_reg;
    logic [WORD_BITS-1:0] mul_a_reg;
    logic [WORD_BITS-1:0] mul_b_reg;

    mexp_mul_status_t     mul_status;
    logic [WORD_BITS-1:0] mul_product;
    logic [WORD_BITS-1:0] one_mod;
    logic [WORD_BITS-1:0] e_shift;

    assign one_mod = (modulus_reg == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
    assign e_shift = e_reg >> 1;

    mexp_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .n       (modulus_reg),
        .status  (mul_status),
        .product (mul_product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            modulus_reg   <= WORD_BITS'(1);
            exponent_reg  <= '0;
            done_reg      <= 1'b0;
            mul_start_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= 1'b0;
            mul_start_reg <= 1'b0;
            if (wr_en)
            begin
                case (wr_index)
                    REG_MODULUS:
                    begin
                        // A zero modulus is refused and the old one kept.
                        if (wr_data != '0)
                        begin
                            modulus_reg <= wr_data;
                        end
                    end
                    REG_EXPONENT: exponent_reg <= wr_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (exponent_reg == '0)
                        begin
                            out_reg  <= WORD_BITS'(1);
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            // The base is reduced as (1 mod n) * base.
                            mul_a_reg     <= one_mod;
                            mul_b_reg     <= base_value;
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE:
                begin
                    if (mul_status.done)
                    begin
                        pow_reg   <= mul_product;
                        res_reg   <= one_mod;
                        e_reg     <= exponent_reg;
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (e_reg[0])
                    begin
                        mul_a_reg     <= res_reg;
                        mul_b_reg     <= pow_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MULT;
                    end
                    else
                    begin
                        mul_a_reg     <= pow_reg;
                        mul_b_reg     <= pow_reg;
                        mul_start_reg <= 1'b1;
                        e_reg         <= e_shift;
                        state_reg     <= ST_SQUARE;
                    end
                end
                ST_MULT:
                begin
                    if (mul_status.done)
                    begin
                        res_reg <= mul_product;
                        e_reg   <= e_shift;
                        if (e_shift == '0)
                        begin
                            out_reg   <= mul_product;
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            mul_a_reg     <= pow_reg;
                            mul_b_reg     <= pow_reg;
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_SQUARE;
                        end
                    end
                end
                ST_SQUARE:
                begin
                    if (mul_status.done)
                    begin
                        pow_reg   <= mul_product;
                        state_reg <= ST_DECIDE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign power_result = out_reg;

    `MEXP_ASSERT_NOW(a_done_when_idle, clk, rst_n, done_reg, state_reg == ST_IDLE)
    `MEXP_ASSERT_NOW(a_mul_start_free, clk, rst_n, mul_start_reg, !mul_status.busy)
    `MEXP_ASSERT_NEXT(a_accept_moves, clk, rst_n, start && !busy, busy || done_reg)

endmodule
